@@ rtl/core/cpme_pkg.sv @@
// Shared constants, types and state codes of the capture period mode estimator.
package cpme_pkg;

  // Batch size and derived widths
  localparam int NUM_SAMPLES = 16;
  localparam int NUM_DIFFS   = NUM_SAMPLES - 1;
  localparam int CAP_W       = 16;
  localparam int DIFF_W      = CAP_W + 1;
  localparam int IDX_W       = $clog2(NUM_SAMPLES);
  localparam int DIDX_W      = $clog2(NUM_DIFFS);
  localparam int CNT_W       = $clog2(NUM_DIFFS + 1);

  // Queue between front and back
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

  // One neighbour difference on its way to the back end
  typedef struct packed {
    logic                     last;
    logic signed [DIFF_W-1:0] diff;
  } cpme_item_t;

  // Back end sequencer states
  typedef enum logic [2:0] {
    BK_FILL,
    BK_LOAD,
    BK_COUNT,
    BK_STEP,
    BK_EMIT
  } cpme_bk_state_t;

endpackage

@@ rtl/core/cpme_front.sv @@
// Front end: accepts captures and forms the signed neighbour differences.
module cpme_front
  import cpme_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [CAP_W-1:0] in_capture,
  input  logic             q_full,
  output logic             q_wr_valid,
  output cpme_item_t       q_wr_item
);

  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  logic [CAP_W-1:0] prev_r;
  logic             accept;
  logic             is_last;

  // Stall the source only while the queue is full
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign is_last   = (idx_r == IDX_W'(NUM_SAMPLES - 1));

  // Push a difference for every capture but the first of a batch
  assign q_wr_valid     = accept && (idx_r != '0);
  assign q_wr_item.last = is_last;
  assign q_wr_item.diff = $signed({1'b0, in_capture}) - $signed({1'b0, prev_r});

  // Advance the position within the batch
  always_comb begin
    idx_nxt = idx_r;
    if (accept) begin
      idx_nxt = is_last ? '0 : idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  // Hold the previous capture
  always_ff @(posedge clk) begin
    if (accept) begin
      prev_r <= in_capture;
    end
  end

endmodule

@@ rtl/core/cpme_queue.sv @@
// Short queue of differences between the front and the back end.
module cpme_queue
  import cpme_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_valid,
  input  cpme_item_t wr_item,
  output logic       full,
  output logic       rd_valid,
  output cpme_item_t rd_item,
  input  logic       rd_pop
);

  cpme_item_t         mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic               do_wr;
  logic               do_rd;

  assign full     = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_item  = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && !full;
  assign do_rd    = rd_pop && rd_valid;

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
      end
      unique case ({do_wr, do_rd})
        2'b10:   cnt_r <= cnt_r + Q_CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - Q_CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  // Store the entry
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

@@ rtl/core/cpme_back.sv @@
// Back end: keeps a batch of differences in a ring and picks the most frequent one.
module cpme_back
  import cpme_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_rd_valid,
  input  cpme_item_t       q_rd_item,
  output logic             q_rd_pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [CAP_W-1:0] out_period
);

  cpme_bk_state_t           state_r,    state_nxt;
  logic signed [DIFF_W-1:0] ring_r [NUM_DIFFS];
  logic signed [DIFF_W-1:0] ring_in;
  logic                     shift_en;
  logic signed [DIFF_W-1:0] cand_r,     cand_nxt;
  logic [CNT_W-1:0]         cnt_r,      cnt_nxt;
  logic [DIDX_W-1:0]        cidx_r,     cidx_nxt;
  logic [DIDX_W-1:0]        pass_r,     pass_nxt;
  logic signed [DIFF_W-1:0] best_key_r, best_key_nxt;
  logic [CNT_W-1:0]         best_cnt_r, best_cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [CAP_W-1:0]         out_data_r, out_data_nxt;
  logic [CNT_W-1:0]         cnt_sum;
  logic                     take;

  assign out_tvalid = out_valid_r;
  assign out_period = out_data_r;

  // Count the candidate against the difference at the head of the ring
  assign cnt_sum = cnt_r + CNT_W'(ring_r[0] == cand_r);
  assign take    = (pass_r == '0) || (cnt_sum > best_cnt_r) ||
                   ((cnt_sum == best_cnt_r) && (cand_r > best_key_r));

  // Sequence fill, count passes and result
  always_comb begin
    state_nxt     = state_r;
    cand_nxt      = cand_r;
    cnt_nxt       = cnt_r;
    cidx_nxt      = cidx_r;
    pass_nxt      = pass_r;
    best_key_nxt  = best_key_r;
    best_cnt_nxt  = best_cnt_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    q_rd_pop      = 1'b0;
    shift_en      = 1'b0;
    ring_in       = ring_r[0];

    unique case (state_r)
      BK_FILL: begin
        q_rd_pop = q_rd_valid;
        shift_en = q_rd_valid;
        ring_in  = q_rd_item.diff;
        if (q_rd_valid && q_rd_item.last) begin
          state_nxt = BK_LOAD;
        end
      end
      BK_LOAD: begin
        cand_nxt  = ring_r[0];
        cnt_nxt   = '0;
        cidx_nxt  = '0;
        pass_nxt  = '0;
        state_nxt = BK_COUNT;
      end
      BK_COUNT: begin
        shift_en = 1'b1;
        cnt_nxt  = cnt_sum;
        cidx_nxt = cidx_r + DIDX_W'(1);
        if (cidx_r == DIDX_W'(NUM_DIFFS - 1)) begin
          if (take) begin
            best_key_nxt = cand_r;
            best_cnt_nxt = cnt_sum;
          end
          cidx_nxt  = '0;
          state_nxt = (pass_r == DIDX_W'(NUM_DIFFS - 1)) ? BK_EMIT : BK_STEP;
        end
      end
      BK_STEP: begin
        // Rotate once so the next candidate sits at the head
        shift_en  = 1'b1;
        cand_nxt  = ring_r[1];
        cnt_nxt   = '0;
        pass_nxt  = pass_r + DIDX_W'(1);
        state_nxt = BK_COUNT;
      end
      BK_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = best_key_r[DIFF_W-1] ? '0 : best_key_r[CAP_W-1:0];
          state_nxt     = BK_FILL;
        end
      end
      default: begin
        state_nxt = BK_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_FILL;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      cidx_r      <= '0;
      pass_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      cidx_r      <= cidx_nxt;
      pass_r      <= pass_nxt;
    end
  end

  // Hold candidate, best so far and the result
  always_ff @(posedge clk) begin
    cand_r     <= cand_nxt;
    best_key_r <= best_key_nxt;
    best_cnt_r <= best_cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  // Rotate the ring towards the head, new entries enter at the tail
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int k = 0; k < NUM_DIFFS - 1; k++) begin
        ring_r[k] <= ring_r[k+1];
      end
      ring_r[NUM_DIFFS-1] <= ring_in;
    end
  end

endmodule

@@ rtl/core/capture_period_mode_estimator.sv @@
// Top level: most frequent neighbour difference over a batch of timer captures.
// Throughput is set by the back end, which compares each difference against the ring of
// NUM_SAMPLES-1 differences one per cycle; meanwhile the front end takes captures of the
// next batch only until the queue is full.
// Reset: synchronous, active low; clears batch position, queue, sequencer and out_tvalid.
module capture_period_mode_estimator
  import cpme_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] capture_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [15:0] period_ticks
);

  logic       q_full;
  logic       q_wr_valid;
  cpme_item_t q_wr_item;
  logic       q_rd_valid;
  cpme_item_t q_rd_item;
  logic       q_rd_pop;

  // Accept captures and form differences
  cpme_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_capture (in_tdata[CAP_W-1:0]),
    .q_full     (q_full),
    .q_wr_valid (q_wr_valid),
    .q_wr_item  (q_wr_item)
  );

  // Decouple front and back
  cpme_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (q_wr_valid),
    .wr_item  (q_wr_item),
    .full     (q_full),
    .rd_valid (q_rd_valid),
    .rd_item  (q_rd_item),
    .rd_pop   (q_rd_pop)
  );

  // Pick the mode and deliver the result
  cpme_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_rd_valid (q_rd_valid),
    .q_rd_item  (q_rd_item),
    .q_rd_pop   (q_rd_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_period (out_tdata[CAP_W-1:0])
  );

endmodule
